@@ rtl/core/chip8_instruction_core_unit_macros.svh @@
// assertion macros used by the core state machine rtl
// no dependencies; taken in by `include where assertions are written
`ifndef CHIP8_INSTRUCTION_CORE_UNIT_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_UNIT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define CHIP8_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// property that must hold in the cycle after its trigger
`define CHIP8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/chip8_pkg.sv @@
// shared types, constants and the opcode decoder of the chip8 core
// no dependencies
`default_nettype none

package chip8_pkg;

	localparam int MEM_BYTES   = 4096;
	localparam int ADDR_W      = 12;
	localparam int NUM_REGS    = 16;
	localparam int STACK_DEPTH = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int SCREEN_W    = 64;
	localparam int SCREEN_H    = 32;
	localparam int ROW_W       = 5;
	localparam int CNT_W       = 4;
	localparam logic [ADDR_W-1:0] START_ADDR_RST = 12'h200;
	localparam logic [3:0] FLAG_REG = 4'hF;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_EXEC  = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_CLS, OP_RET, OP_JP, OP_CALL, OP_SKIP, OP_ALU, OP_ALUF,
		OP_LDI, OP_JPV0, OP_DRAW, OP_SETDT, OP_SETST, OP_ADDI, OP_BCD,
		OP_STORE, OP_LOAD
	} op_t;

	typedef struct packed {
		kind_t        kind;
		logic [11:0]  address;
		logic [7:0]   data;
		logic [15:0]  key_states;
		logic [7:0]   random_byte;
		logic [4:0]   row_index;
	} request_t;

	typedef struct packed {
		logic [11:0]  program_counter;
		logic [7:0]   flag_register;
		logic [7:0]   delay_count;
		logic [7:0]   sound_count;
		logic         sound_on;
		logic [63:0]  row_pixels;
	} result_t;

	typedef struct packed {
		logic accept;
		logic clr_mem;
		logic fetch_hi;
		logic fetch_lo;
		logic rd_x;
		logic rd_y;
		logic exec;
		logic ret2;
		logic wb_f;
		logic draw_wr;
		logic bcd_h;
		logic bcd_t;
		logic bcd_o;
		logic st_rd;
		logic st_wr;
		logic ld_wr;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic n_zero;
		logic cnt_last;
		logic clr_last;
	} dp_status_t;

	function automatic op_t decode(input logic [7:0] hi, input logic [7:0] lo);
		op_t op;
		op = OP_NOP;
		case (hi[7:4])
			4'h0: begin
				if (hi[3:0] == 4'h0 && lo == 8'hE0) op = OP_CLS;
				else if (hi[3:0] == 4'h0 && lo == 8'hEE) op = OP_RET;
			end
			4'h1: op = OP_JP;
			4'h2: op = OP_CALL;
			4'h3, 4'h4, 4'h5, 4'h9: op = OP_SKIP;
			4'h6, 4'h7, 4'hC: op = OP_ALU;
			4'h8: begin
				case (lo[3:0])
					4'h0, 4'h1, 4'h2, 4'h3: op = OP_ALU;
					4'h4, 4'h5, 4'h6, 4'h7, 4'hE: op = OP_ALUF;
					default: op = OP_NOP;
				endcase
			end
			4'hA: op = OP_LDI;
			4'hB: op = OP_JPV0;
			4'hD: op = OP_DRAW;
			4'hE: begin
				if (lo == 8'h9E || lo == 8'hA1) op = OP_SKIP;
			end
			4'hF: begin
				case (lo)
					8'h07: op = OP_ALU;
					8'h15: op = OP_SETDT;
					8'h18: op = OP_SETST;
					8'h1E: op = OP_ADDI;
					8'h33: op = OP_BCD;
					8'h55: op = OP_STORE;
					8'h65: op = OP_LOAD;
					default: op = OP_NOP;
				endcase
			end
			default: op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/chip8_dpath.sv @@
// datapath of the chip8 core: memories, registers, alu, sprite unit
// depends on chip8_pkg
`default_nettype none

module chip8_dpath import chip8_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  request_t            request,
	input  logic                cfg_valid,
	input  logic [ADDR_W-1:0]   cfg_data,
	input  ctrl_cmd_t           cmd,
	output dp_status_t          status,
	output result_t             result
);

	logic [7:0]          mem_q [MEM_BYTES];
	logic [7:0]          mem_rd_q;
	logic [7:0]          vreg_q [NUM_REGS];
	logic [NUM_REGS-1:0] vvld_q;
	logic [7:0]          vrd_q;
	logic [ADDR_W-1:0]   stk_q [STACK_DEPTH];
	logic [ADDR_W-1:0]   stk_rd_q;
	logic [SP_W-1:0]     sp_q;
	logic [SCREEN_W-1:0] scr_q [SCREEN_H];
	logic [SCREEN_H-1:0] scr_vld_q;
	logic [SCREEN_W-1:0] scr_rd_q;

	logic [ADDR_W-1:0] pc_q, idx_q, clr_q;
	logic [7:0]  vf_q, dt_q, st_q, ir_hi_q, ir_lo_q, vx_q, vy_q, rnd_q;
	logic [15:0] keys_q;
	logic        flag_q, row_sel_q;
	logic [CNT_W-1:0] cnt_q;

	op_t op;
	logic [3:0] fx, fy, fn;
	logic [ADDR_W-1:0] nnn, pc_inc, ibase;
	logic [SP_W-1:0] sp_inc, sp_dec;

	assign op     = decode(ir_hi_q, ir_lo_q);
	assign fx     = ir_hi_q[3:0];
	assign fy     = ir_lo_q[7:4];
	assign fn     = ir_lo_q[3:0];
	assign nnn    = {fx, ir_lo_q};
	assign pc_inc = pc_q + 12'd2;
	assign ibase  = idx_q + {{(ADDR_W-CNT_W){1'b0}}, cnt_q};
	assign sp_inc = (sp_q == SP_W'(STACK_DEPTH-1)) ? '0 : sp_q + 1'b1;
	assign sp_dec = (sp_q == '0) ? SP_W'(STACK_DEPTH-1) : sp_q - 1'b1;

	// alu, vy arrives on the register read port during execute
	logic [7:0] vy_now, alu_res;
	logic [8:0] sum9;
	logic       alu_flag, skip_take;
	assign vy_now = vrd_q;
	assign sum9   = {1'b0, vx_q} + {1'b0, vy_now};

	always_comb begin
		alu_res  = ir_lo_q;
		alu_flag = 1'b0;
		case (ir_hi_q[7:4])
			4'h6: alu_res = ir_lo_q;
			4'h7: alu_res = vx_q + ir_lo_q;
			4'hC: alu_res = rnd_q & ir_lo_q;
			4'hF: alu_res = dt_q;
			4'h8: begin
				case (fn)
					4'h0: alu_res = vy_now;
					4'h1: alu_res = vx_q | vy_now;
					4'h2: alu_res = vx_q & vy_now;
					4'h3: alu_res = vx_q ^ vy_now;
					4'h4: begin alu_res = sum9[7:0]; alu_flag = sum9[8]; end
					4'h5: begin alu_res = vx_q - vy_now; alu_flag = vx_q >= vy_now; end
					4'h6: begin alu_res = {1'b0, vx_q[7:1]}; alu_flag = vx_q[0]; end
					4'h7: begin alu_res = vy_now - vx_q; alu_flag = vy_now >= vx_q; end
					4'hE: begin alu_res = {vx_q[6:0], 1'b0}; alu_flag = vx_q[7]; end
					default: alu_res = vx_q;
				endcase
			end
			default: alu_res = ir_lo_q;
		endcase
	end

	always_comb begin
		case (ir_hi_q[7:4])
			4'h3: skip_take = (vx_q == ir_lo_q);
			4'h4: skip_take = (vx_q != ir_lo_q);
			4'h5: skip_take = (vx_q == vy_now);
			4'h9: skip_take = (vx_q != vy_now);
			4'hE: skip_take = (ir_lo_q == 8'h9E) ? keys_q[vx_q[3:0]] : !keys_q[vx_q[3:0]];
			default: skip_take = 1'b0;
		endcase
	end

	// decimal digits by compare and reciprocal multiply
	logic [1:0]  hund;
	logic [6:0]  rem1;
	logic [14:0] tprod;
	logic [3:0]  tens, ones;
	always_comb begin
		if (vx_q >= 8'd200) begin hund = 2'd2; rem1 = 7'(vx_q - 8'd200); end
		else if (vx_q >= 8'd100) begin hund = 2'd1; rem1 = 7'(vx_q - 8'd100); end
		else begin hund = 2'd0; rem1 = vx_q[6:0]; end
		tprod = {8'b0, rem1} * 15'd205;
		tens  = tprod[14:11];
		ones  = 4'(rem1 - 7'(tens) * 7'd10);
	end

	// sprite row rotated into place, wrapping at the right edge
	logic [ROW_W-1:0]      drow;
	logic [2*SCREEN_W-1:0] rot;
	logic [SCREEN_W-1:0]   s_rot;
	assign drow  = vy_q[ROW_W-1:0] + {{(ROW_W-CNT_W){1'b0}}, cnt_q};
	assign rot   = {2{mem_rd_q, {(SCREEN_W-8){1'b0}}}} >> vx_q[5:0];
	assign s_rot = rot[SCREEN_W-1:0];

	// main memory port
	logic [ADDR_W-1:0] mem_raddr, mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_we;
	always_comb begin
		mem_raddr = ibase;
		if (cmd.fetch_hi) mem_raddr = pc_q;
		else if (cmd.fetch_lo) mem_raddr = pc_q + 12'd1;
		mem_we    = 1'b1;
		mem_waddr = ibase;
		mem_wdata = vrd_q;
		if (cmd.clr_mem) begin
			mem_waddr = clr_q; mem_wdata = 8'd0;
		end else if (cmd.accept && request.kind == KIND_WRITE) begin
			mem_waddr = request.address; mem_wdata = request.data;
		end else if (cmd.bcd_h) begin
			mem_waddr = idx_q; mem_wdata = {6'b0, hund};
		end else if (cmd.bcd_t) begin
			mem_waddr = idx_q + 12'd1; mem_wdata = {4'b0, tens};
		end else if (cmd.bcd_o) begin
			mem_waddr = idx_q + 12'd2; mem_wdata = {4'b0, ones};
		end else if (!cmd.st_wr) begin
			mem_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		mem_rd_q <= mem_q[mem_raddr];
	end

	// general register port
	logic [3:0] vraddr, vwaddr;
	logic [7:0] vwdata;
	logic       vwe;
	always_comb begin
		vraddr = fx;
		if (cmd.rd_y) vraddr = (op == OP_JPV0) ? 4'h0 : fy;
		else if (cmd.st_rd) vraddr = cnt_q;
		vwe    = 1'b1;
		vwaddr = fx;
		vwdata = alu_res;
		if (cmd.wb_f) begin
			vwaddr = FLAG_REG; vwdata = {7'b0, flag_q};
		end else if (cmd.ld_wr) begin
			vwaddr = cnt_q; vwdata = mem_rd_q;
		end else if (!(cmd.exec && (op == OP_ALU || op == OP_ALUF))) begin
			vwe = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vwe) vreg_q[vwaddr] <= vwdata;
		vrd_q <= vvld_q[vraddr] ? vreg_q[vraddr] : 8'd0;
	end

	// return stack
	always_ff @(posedge clk) begin
		if (cmd.exec && op == OP_CALL) stk_q[sp_q] <= pc_inc;
		stk_rd_q <= stk_q[sp_dec];
	end

	// screen rows
	logic [ROW_W-1:0] sraddr;
	assign sraddr = (cmd.accept && request.kind == KIND_READ) ? request.row_index : drow;
	always_ff @(posedge clk) begin
		if (cmd.draw_wr) scr_q[drow] <= scr_rd_q ^ s_rot;
		scr_rd_q <= scr_vld_q[sraddr] ? scr_q[sraddr] : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			keys_q <= request.key_states;
			rnd_q  <= request.random_byte;
		end
		if (cmd.fetch_lo) ir_hi_q <= mem_rd_q;
		if (cmd.rd_x)     ir_lo_q <= mem_rd_q;
		if (cmd.rd_y)     vx_q    <= vrd_q;
		if (cmd.exec)     vy_q    <= vrd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= START_ADDR_RST;
			idx_q     <= '0;
			sp_q      <= '0;
			dt_q      <= '0;
			st_q      <= '0;
			vf_q      <= '0;
			flag_q    <= 1'b0;
			cnt_q     <= '0;
			clr_q     <= '0;
			row_sel_q <= 1'b0;
			vvld_q    <= '0;
			scr_vld_q <= '0;
		end else begin
			if (cmd.clr_mem) clr_q <= clr_q + 1'b1;
			if (vwe) begin
				vvld_q[vwaddr] <= 1'b1;
				if (vwaddr == FLAG_REG) vf_q <= vwdata;
			end
			if (cmd.draw_wr) scr_vld_q[drow] <= 1'b1;
			if (cmd.accept) begin
				row_sel_q <= (request.kind == KIND_READ);
				if (request.kind == KIND_TICK) begin
					if (dt_q != 8'd0) dt_q <= dt_q - 1'b1;
					if (st_q != 8'd0) st_q <= st_q - 1'b1;
				end
			end
			if (cmd.exec) begin
				cnt_q  <= '0;
				flag_q <= (op == OP_ALUF) ? alu_flag : 1'b0;
				pc_q   <= pc_inc;
				case (op)
					OP_CLS:   scr_vld_q <= '0;
					OP_RET:   sp_q <= sp_dec;
					OP_JP:    pc_q <= nnn;
					OP_CALL:  begin pc_q <= nnn; sp_q <= sp_inc; end
					OP_SKIP:  if (skip_take) pc_q <= pc_q + 12'd4;
					OP_LDI:   idx_q <= nnn;
					OP_JPV0:  pc_q <= nnn + {4'b0, vy_now};
					OP_SETDT: dt_q <= vx_q;
					OP_SETST: st_q <= vx_q;
					OP_ADDI:  idx_q <= idx_q + {4'b0, vx_q};
					default:  ;
				endcase
			end
			if (cmd.ret2) pc_q <= stk_rd_q;
			if (cmd.draw_wr) flag_q <= flag_q | (|(scr_rd_q & s_rot));
			if (cmd.draw_wr || cmd.st_wr || cmd.ld_wr) cnt_q <= cnt_q + 1'b1;
			if (cfg_valid) pc_q <= cfg_data;
		end
	end

	assign status.op       = op;
	assign status.n_zero   = (fn == 4'h0);
	assign status.cnt_last = (op == OP_DRAW) ? (cnt_q == fn - 4'd1) : (cnt_q == fx);
	assign status.clr_last = (clr_q == ADDR_W'(MEM_BYTES-1));

	assign result.program_counter = pc_q;
	assign result.flag_register   = vf_q;
	assign result.delay_count     = dt_q;
	assign result.sound_count     = st_q;
	assign result.sound_on        = (st_q != 8'd0);
	assign result.row_pixels      = row_sel_q ? scr_rd_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/chip8_ctrl.sv @@
// sequencing state machine of the chip8 core
// depends on chip8_pkg and the assertion macro header
`default_nettype none
`include "chip8_instruction_core_unit_macros.svh"

module chip8_ctrl import chip8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  kind_t      kind,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [18:0] {
		S_CLEAR    = 19'b1 << 0,
		S_IDLE     = 19'b1 << 1,
		S_FETCH_HI = 19'b1 << 2,
		S_FETCH_LO = 19'b1 << 3,
		S_RD_X     = 19'b1 << 4,
		S_RD_Y     = 19'b1 << 5,
		S_EXEC     = 19'b1 << 6,
		S_RET2     = 19'b1 << 7,
		S_WB_F     = 19'b1 << 8,
		S_DRAW_RD  = 19'b1 << 9,
		S_DRAW_WR  = 19'b1 << 10,
		S_BCD_H    = 19'b1 << 11,
		S_BCD_T    = 19'b1 << 12,
		S_BCD_O    = 19'b1 << 13,
		S_ST_RD    = 19'b1 << 14,
		S_ST_WR    = 19'b1 << 15,
		S_LD_RD    = 19'b1 << 16,
		S_LD_WR    = 19'b1 << 17,
		S_DONE     = 19'b1 << 18
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:    if (status.clr_last) state_d = S_IDLE;
			S_IDLE:     if (start) state_d = (kind == KIND_EXEC) ? S_FETCH_HI : S_DONE;
			S_FETCH_HI: state_d = S_FETCH_LO;
			S_FETCH_LO: state_d = S_RD_X;
			S_RD_X:     state_d = S_RD_Y;
			S_RD_Y:     state_d = S_EXEC;
			S_EXEC: begin
				case (status.op)
					OP_RET:   state_d = S_RET2;
					OP_ALUF:  state_d = S_WB_F;
					OP_DRAW:  state_d = status.n_zero ? S_WB_F : S_DRAW_RD;
					OP_BCD:   state_d = S_BCD_H;
					OP_STORE: state_d = S_ST_RD;
					OP_LOAD:  state_d = S_LD_RD;
					default:  state_d = S_DONE;
				endcase
			end
			S_RET2:     state_d = S_DONE;
			S_WB_F:     state_d = S_DONE;
			S_DRAW_RD:  state_d = S_DRAW_WR;
			S_DRAW_WR:  state_d = status.cnt_last ? S_WB_F : S_DRAW_RD;
			S_BCD_H:    state_d = S_BCD_T;
			S_BCD_T:    state_d = S_BCD_O;
			S_BCD_O:    state_d = S_DONE;
			S_ST_RD:    state_d = S_ST_WR;
			S_ST_WR:    state_d = status.cnt_last ? S_DONE : S_ST_RD;
			S_LD_RD:    state_d = S_LD_WR;
			S_LD_WR:    state_d = status.cnt_last ? S_DONE : S_LD_RD;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.accept   = accept;
	assign cmd.clr_mem  = (state_q == S_CLEAR);
	assign cmd.fetch_hi = (state_q == S_FETCH_HI);
	assign cmd.fetch_lo = (state_q == S_FETCH_LO);
	assign cmd.rd_x     = (state_q == S_RD_X);
	assign cmd.rd_y     = (state_q == S_RD_Y);
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.ret2     = (state_q == S_RET2);
	assign cmd.wb_f     = (state_q == S_WB_F);
	assign cmd.draw_wr  = (state_q == S_DRAW_WR);
	assign cmd.bcd_h    = (state_q == S_BCD_H);
	assign cmd.bcd_t    = (state_q == S_BCD_T);
	assign cmd.bcd_o    = (state_q == S_BCD_O);
	assign cmd.st_rd    = (state_q == S_ST_RD);
	assign cmd.st_wr    = (state_q == S_ST_WR);
	assign cmd.ld_wr    = (state_q == S_LD_WR);

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	`CHIP8_ASSERT_NEXT(a_done_frees, clk, arst_n, done, !busy, "core still busy after result")
	`CHIP8_ASSERT_NEXT(a_short_item, clk, arst_n, accept && kind != KIND_EXEC, done, "single step item gave no result next cycle")
	`CHIP8_ASSERT_NOW(a_exec_fetch, clk, arst_n, state_q == S_EXEC, $past(state_q, 4) == S_FETCH_HI, "execute not preceded by fetch")

endmodule

`default_nettype wire

@@ rtl/core/chip8_instruction_core_unit.sv @@
// top level of the chip8 instruction core
// depends on chip8_pkg, chip8_ctrl and chip8_dpath
//
// channel   direction  handshake               payload
// request   in         start, taken when !busy request (request_t)
// result    out        done, one cycle strobe  result (result_t)
// config    in         cfg_valid / cfg_ready   cfg_data (start address)
//
// after reset the core sweeps every byte of main memory to zero with busy high
// write, tick and read row requests go from idle straight to done; execute passes
// fetch, register read and execute states, then a flag write or return if needed;
// draw adds read and write per row, store and load per register, digit store writes
// each digit; the result cannot be stalled; it is shown for the single done cycle
// a config write loads the program counter and is taken only while the core is idle
`default_nettype none

module chip8_instruction_core_unit import chip8_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  request_t          request,
	output logic              done,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ADDR_W-1:0] cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// config writes only between requests, so they never land mid instruction
	assign cfg_ready = !busy;

	chip8_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (request.kind),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	chip8_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

`default_nettype wire

@@ bench/chip8_bench_pkg.sv @@
// instruction encodings used by the chip8 bench to build and predict programs
// no dependencies
`default_nettype none

package chip8_bench_pkg;

	// high nibble of the instruction word
	localparam logic [3:0] OPC_SYS  = 4'h0;
	localparam logic [3:0] OPC_JP   = 4'h1;
	localparam logic [3:0] OPC_CALL = 4'h2;
	localparam logic [3:0] OPC_SEQI = 4'h3;
	localparam logic [3:0] OPC_SNEI = 4'h4;
	localparam logic [3:0] OPC_SEQ  = 4'h5;
	localparam logic [3:0] OPC_LDV  = 4'h6;
	localparam logic [3:0] OPC_ADDV = 4'h7;
	localparam logic [3:0] OPC_ALU  = 4'h8;
	localparam logic [3:0] OPC_SNE  = 4'h9;
	localparam logic [3:0] OPC_LDI  = 4'hA;
	localparam logic [3:0] OPC_JPV0 = 4'hB;
	localparam logic [3:0] OPC_RND  = 4'hC;
	localparam logic [3:0] OPC_DRW  = 4'hD;
	localparam logic [3:0] OPC_KEY  = 4'hE;
	localparam logic [3:0] OPC_MISC = 4'hF;

	// low nibble of the register-register group
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	// low bytes of the system, key and misc groups
	localparam logic [7:0] LO_CLS     = 8'hE0;
	localparam logic [7:0] LO_RET     = 8'hEE;
	localparam logic [7:0] LO_SKP     = 8'h9E;
	localparam logic [7:0] LO_SKNP    = 8'hA1;
	localparam logic [7:0] LO_GETDT   = 8'h07;
	localparam logic [7:0] LO_WAITKEY = 8'h0A;
	localparam logic [7:0] LO_SETDT   = 8'h15;
	localparam logic [7:0] LO_SETST   = 8'h18;
	localparam logic [7:0] LO_ADDI    = 8'h1E;
	localparam logic [7:0] LO_FONT    = 8'h29;
	localparam logic [7:0] LO_BCD     = 8'h33;
	localparam logic [7:0] LO_STORE   = 8'h55;
	localparam logic [7:0] LO_LOAD    = 8'h65;

endpackage

`default_nettype wire

@@ bench/chip8_instruction_core_unit_checker.sv @@
// checker for the chip8 core: mirrors its state, predicts each result and compares
// depends on chip8_pkg and chip8_bench_pkg
`default_nettype none

module chip8_instruction_core_unit_checker import chip8_pkg::*, chip8_bench_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  request_t          request,
	input  logic              done,
	input  result_t           result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [ADDR_W-1:0] cfg_data,
	output int                errors,
	output int                pending,
	output logic [11:0]       shadow_pc,
	output logic              return_ok
);

	logic [7:0]  mem_m [MEM_BYTES];
	logic [7:0]  vreg [16];
	logic [11:0] idx_m;
	logic [11:0] pc_m;
	logic [11:0] stack_m [16];
	logic [15:0] stack_written;
	logic [3:0]  sp_m;
	logic [7:0]  delay_m, sound_m;
	logic [63:0] screen_m [SCREEN_H];
	result_t     expected_results [$];

	assign shadow_pc = pc_m;
	assign return_ok = stack_written[sp_m - 4'd1];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic draw(input logic [7:0] xc, input logic [7:0] yc, input logic [3:0] rows);
		logic [63:0] s;
		logic [5:0]  xx;
		logic [4:0]  line;
		logic        hit;
		xx = xc[5:0];
		hit = 1'b0;
		for (int r = 0; r < rows; r++) begin
			s = {mem_m[idx_m + 12'(r)], 56'd0};
			if (xx != 0)
				s = (s >> xx) | (s << (7'd64 - xx));
			line = yc[4:0] + 5'(r);
			if (|(screen_m[line] & s))
				hit = 1'b1;
			screen_m[line] ^= s;
		end
		vreg[FLAG_REG] = {7'd0, hit};
	endtask

	task automatic execute(input logic [15:0] keys, input logic [7:0] rnd);
		logic [7:0]  hi, lo, vx, vy;
		logic [3:0]  x, y, n;
		logic [11:0] nnn;
		logic [8:0]  wide;
		logic        skip;
		hi = mem_m[pc_m];
		lo = mem_m[pc_m + 12'd1];
		x = hi[3:0];
		y = lo[7:4];
		n = lo[3:0];
		nnn = {x, lo};
		vx = vreg[x];
		vy = vreg[y];
		skip = 1'b0;
		pc_m = pc_m + 12'd2;
		case (hi[7:4])
			OPC_SYS: begin
				if (x == 4'd0 && lo == LO_CLS) begin
					for (int r = 0; r < SCREEN_H; r++) screen_m[r] = '0;
				end else if (x == 4'd0 && lo == LO_RET) begin
					sp_m = sp_m - 4'd1;
					pc_m = stack_m[sp_m];
				end
			end
			OPC_JP: pc_m = nnn;
			OPC_CALL: begin
				stack_m[sp_m] = pc_m;
				stack_written[sp_m] = 1'b1;
				sp_m = sp_m + 4'd1;
				pc_m = nnn;
			end
			OPC_SEQI: skip = (vx == lo);
			OPC_SNEI: skip = (vx != lo);
			OPC_SEQ:  skip = (vx == vy);
			OPC_LDV:  vreg[x] = lo;
			OPC_ADDV: vreg[x] = vx + lo;
			OPC_ALU: begin
				case (n)
					ALU_MOV: vreg[x] = vy;
					ALU_OR:  vreg[x] = vx | vy;
					ALU_AND: vreg[x] = vx & vy;
					ALU_XOR: vreg[x] = vx ^ vy;
					ALU_ADD: begin
						wide = {1'b0, vx} + {1'b0, vy};
						vreg[x] = wide[7:0];
						vreg[FLAG_REG] = {7'd0, wide[8]};
					end
					ALU_SUB: begin
						vreg[x] = vx - vy;
						vreg[FLAG_REG] = {7'd0, vx >= vy};
					end
					ALU_SHR: begin
						vreg[x] = vx >> 1;
						vreg[FLAG_REG] = {7'd0, vx[0]};
					end
					ALU_SUBN: begin
						vreg[x] = vy - vx;
						vreg[FLAG_REG] = {7'd0, vy >= vx};
					end
					ALU_SHL: begin
						vreg[x] = vx << 1;
						vreg[FLAG_REG] = {7'd0, vx[7]};
					end
					default: ;
				endcase
			end
			OPC_SNE:  skip = (vx != vy);
			OPC_LDI:  idx_m = nnn;
			OPC_JPV0: pc_m = nnn + {4'd0, vreg[0]};
			OPC_RND:  vreg[x] = rnd & lo;
			OPC_DRW:  draw(vx, vy, n);
			OPC_KEY: begin
				if (lo == LO_SKP) skip = keys[vx[3:0]];
				else if (lo == LO_SKNP) skip = !keys[vx[3:0]];
			end
			default: begin
				case (lo)
					LO_GETDT: vreg[x] = delay_m;
					LO_SETDT: delay_m = vx;
					LO_SETST: sound_m = vx;
					LO_ADDI:  idx_m = idx_m + {4'd0, vx};
					LO_BCD: begin
						mem_m[idx_m]         = vx / 8'd100;
						mem_m[idx_m + 12'd1] = (vx % 8'd100) / 8'd10;
						mem_m[idx_m + 12'd2] = vx % 8'd10;
					end
					LO_STORE: for (int i = 0; i <= x; i++) mem_m[idx_m + 12'(i)] = vreg[i];
					LO_LOAD:  for (int i = 0; i <= x; i++) vreg[i] = mem_m[idx_m + 12'(i)];
					default: ;
				endcase
			end
		endcase
		if (skip)
			pc_m = pc_m + 12'd2;
	endtask

	task automatic predict_result(input request_t r);
		result_t e;
		e = '0;
		case (r.kind)
			KIND_WRITE: mem_m[r.address] = r.data;
			KIND_EXEC:  execute(r.key_states, r.random_byte);
			KIND_TICK: begin
				if (delay_m != 0) delay_m--;
				if (sound_m != 0) sound_m--;
			end
			default: e.row_pixels = screen_m[r.row_index];
		endcase
		e.program_counter = pc_m;
		e.flag_register = vreg[FLAG_REG];
		e.delay_count = delay_m;
		e.sound_count = sound_m;
		e.sound_on = (sound_m != 0);
		expected_results.push_back(e);
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			for (int i = 0; i < MEM_BYTES; i++) mem_m[i] = '0;
			for (int i = 0; i < 16; i++) begin
				vreg[i] = '0;
				stack_m[i] = '0;
			end
			for (int i = 0; i < SCREEN_H; i++) screen_m[i] = '0;
			stack_written = '0;
			idx_m = '0;
			sp_m = '0;
			delay_m = '0;
			sound_m = '0;
			pc_m = START_ADDR_RST;
			expected_results.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", 64'(result.program_counter), 64'd0);
				end else begin
					e = expected_results.pop_front();
					if (result.program_counter !== e.program_counter)
						report("program_counter", 64'(result.program_counter),
							64'(e.program_counter));
					if (result.flag_register !== e.flag_register)
						report("flag_register", 64'(result.flag_register),
							64'(e.flag_register));
					if (result.delay_count !== e.delay_count)
						report("delay_count", 64'(result.delay_count), 64'(e.delay_count));
					if (result.sound_count !== e.sound_count)
						report("sound_count", 64'(result.sound_count), 64'(e.sound_count));
					if (result.sound_on !== e.sound_on)
						report("sound_on", 64'(result.sound_on), 64'(e.sound_on));
					if (result.row_pixels !== e.row_pixels)
						report("row_pixels", result.row_pixels, e.row_pixels);
				end
			end
			if (cfg_valid && cfg_ready)
				pc_m = cfg_data;
			if (start && !busy)
				predict_result(request);
			pending = expected_results.size();
		end
	end

endmodule

`default_nettype wire

@@ bench/chip8_instruction_core_unit_tb.sv @@
// top of the chip8 core bench: clock, reset, program and noise requests, verdict
// depends on chip8_pkg, chip8_bench_pkg, the checker module and the core rtl
`default_nettype none

module chip8_instruction_core_unit_tb;
	import chip8_pkg::*;
	import chip8_bench_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	request_t          request;
	logic              done;
	result_t           result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [ADDR_W-1:0] cfg_data;

	int          errors;
	int          pending;
	logic [11:0] shadow_pc;
	logic        return_ok;

	// request counts per kind, for the closing summary
	int n_write, n_exec, n_tick, n_read, n_cfg;

	chip8_instruction_core_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	chip8_instruction_core_unit_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.shadow_pc (shadow_pc),
		.return_ok (return_ok)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run, memory sweep included
	initial begin
		#12000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// mostly short pauses, sometimes none, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// present one request and hold it until the core takes it; caller is at a rising edge
	task automatic send(input request_t r, input int gap);
		bit taken;
		start <= 1'b1;
		request <= r;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		case (r.kind)
			KIND_WRITE: n_write++;
			KIND_EXEC:  n_exec++;
			KIND_TICK:  n_tick++;
			default:    n_read++;
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// random fill for the fields a request kind does not use
	function automatic request_t noise_request(input kind_t k);
		request_t r;
		r.kind        = k;
		r.address     = 12'($urandom());
		r.data        = 8'($urandom());
		r.key_states  = 16'($urandom());
		r.random_byte = 8'($urandom());
		r.row_index   = 5'($urandom());
		return r;
	endfunction

	task automatic write_byte(input logic [11:0] a, input logic [7:0] d, input int gap);
		request_t r;
		r = noise_request(KIND_WRITE);
		r.address = a;
		r.data = d;
		send(r, gap);
	endtask

	// place one instruction at the shadow pc and execute it
	task automatic run_op(input logic [7:0] hi, input logic [7:0] lo, input logic [15:0] keys);
		request_t r;
		logic [11:0] at;
		int gap;
		at = shadow_pc;
		write_byte(at, hi, 0);
		write_byte(at + 12'd1, lo, 0);
		r = noise_request(KIND_EXEC);
		r.key_states = keys;
		gap = pick_gap();
		// the shadow pc must settle before the next instruction is placed
		send(r, (gap < 1) ? 1 : gap);
	endtask

	// stop sending and wait until every request has been answered
	task automatic wait_idle();
		bit quiet;
		start <= 1'b0;
		do begin
			@(negedge clk);
			quiet = (pending == 0) && !busy;
			@(posedge clk);
		end while (!quiet);
		repeat (48) @(posedge clk);
	endtask

	task automatic set_start(input logic [11:0] a);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_data <= a;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		n_cfg++;
		@(posedge clk);
	endtask

	// random instruction; a return only where the stack slot holds a call
	function automatic logic [15:0] pick_op();
		logic [3:0] g;
		logic [7:0] hi, lo;
		int c;
		g = 4'($urandom());
		hi = {g, 4'($urandom())};
		lo = 8'($urandom());
		c = $urandom_range(0, 9);
		case (g)
			OPC_SYS: begin
				hi = 8'($urandom_range(0, 3) == 0 ? $urandom() : 0) & 8'h0F;
				if (c < 3) lo = LO_CLS;
				else if (c < 8 && return_ok) lo = LO_RET;
				// never return through an empty stack slot
				if (lo == LO_RET && !return_ok) lo = LO_CLS;
			end
			OPC_ALU: begin
				case (c)
					0: lo[3:0] = ALU_ADD;
					1: lo[3:0] = ALU_SUB;
					2: lo[3:0] = ALU_SHR;
					3: lo[3:0] = ALU_SUBN;
					4: lo[3:0] = ALU_SHL;
					default: ;
				endcase
			end
			OPC_KEY: if (c < 8) lo = c[0] ? LO_SKP : LO_SKNP;
			OPC_MISC: begin
				case (c)
					0: lo = LO_GETDT;
					1: lo = LO_SETDT;
					2: lo = LO_SETST;
					3: lo = LO_ADDI;
					4: lo = LO_BCD;
					5: lo = LO_STORE;
					6: lo = LO_LOAD;
					7: lo = c[0] ? LO_WAITKEY : LO_FONT;
					default: ;
				endcase
			end
			default: ;
		endcase
		return {hi, lo};
	endfunction

	initial begin
		logic [15:0] op;
		int items;
		int phase_mark;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		n_write = 0;
		n_exec = 0;
		n_tick = 0;
		n_read = 0;
		n_cfg = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// memory sweep after reset runs with busy high
		wait_idle();
		set_start(START_ADDR_RST);

		// directed part: field extremes, flag cases, digit store, stack, draw, timers, keys, unfinished ops
		write_byte(12'h000, 8'h00, 0);
		write_byte(12'hFFF, 8'hFF, 1);
		run_op({OPC_LDV, 4'h0}, 8'hFF, 16'h0000);
		run_op({OPC_LDV, 4'h1}, 8'h01, 16'h0000);
		run_op({OPC_ALU, 4'h0}, {4'h1, ALU_ADD}, 16'h0000);
		run_op({OPC_ALU, 4'h1}, {4'h0, ALU_SUB}, 16'h0000);
		run_op({OPC_LDV, 4'hF}, 8'h80, 16'h0000);
		run_op({OPC_ALU, 4'hF}, {4'hF, ALU_SHL}, 16'h0000);
		run_op({OPC_LDI, 4'h3}, 8'h00, 16'h0000);
		run_op({OPC_MISC, 4'h0}, LO_BCD, 16'h0000);
		run_op({OPC_DRW, 4'h0}, 8'h13, 16'h0000);
		run_op({OPC_DRW, 4'h0}, 8'h10, 16'h0000);
		send(noise_request(KIND_READ), 0);
		run_op({OPC_MISC, 4'h1}, LO_SETDT, 16'hFFFF);
		run_op({OPC_MISC, 4'h1}, LO_SETST, 16'hFFFF);
		send(noise_request(KIND_TICK), 0);
		run_op({OPC_KEY, 4'h0}, LO_SKP, 16'hFFFF);
		run_op({OPC_KEY, 4'h0}, LO_SKNP, 16'h0000);
		run_op({OPC_MISC, 4'h2}, LO_WAITKEY, 16'h0000);
		run_op({OPC_MISC, 4'h2}, LO_FONT, 16'h0000);
		run_op({OPC_CALL, 4'h4}, 8'h00, 16'h0000);
		run_op({OPC_SYS, 4'h0}, LO_RET, 16'h0000);
		run_op({OPC_SYS, 4'h0}, LO_CLS, 16'h0000);
		run_op({OPC_JPV0, 4'h2}, 8'h00, 16'h0000);

		// pause until all answered, then move the start address to each end
		wait_idle();
		set_start(12'hFFF);
		run_op({OPC_LDV, 4'h2}, 8'h5A, 16'h0000);
		wait_idle();
		set_start(12'h000);

		// random part: mostly placed instructions, the rest plain writes, ticks and reads
		items = 0;
		phase_mark = 0;
		while (items < 1250) begin
			if ($urandom_range(0, 9) < 7) begin
				op = pick_op();
				run_op(op[15:8], op[7:0], 16'($urandom()));
				items += 3;
			end else begin
				case ($urandom_range(0, 2))
					0: send(noise_request(KIND_WRITE), pick_gap());
					1: send(noise_request(KIND_TICK), pick_gap());
					default: send(noise_request(KIND_READ), pick_gap());
				endcase
				items++;
			end
			// new start address between phases, extremes included
			if (items - phase_mark >= 300) begin
				phase_mark = items;
				wait_idle();
				case ($urandom_range(0, 2))
					0: set_start(12'h000);
					1: set_start(12'hFFF);
					default: set_start(12'($urandom()));
				endcase
			end
		end

		wait_idle();
		$display("covered %0d writes, %0d executes, %0d ticks, %0d row reads",
			n_write, n_exec, n_tick, n_read);
		$display("start address rewritten %0d times between phases", n_cfg);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
